FILE: rtl/core/mmsi_pkg.sv
// Shared types and constants for the music macro string interpreter.
package mmsi_pkg;

  // Note number of octave 0, note C.
  localparam int NOTE_BASE       = 24;
  localparam int MAX_OCTAVE      = 6;
  localparam int MAX_NOTE_NUMBER = 84;

  localparam logic [15:0] QUARTER_RESET = 16'd5000;

  // Result queue depth, must be a power of two.
  localparam int OQ_DEPTH = 4;

  typedef enum logic [2:0] {
    EV_NOTE       = 3'd0,
    EV_REST       = 3'd1,
    EV_BAD_OCTAVE = 3'd2,
    EV_BAD_NOTE   = 3'd3,
    EV_SYNTAX     = 3'd4
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [6:0]  note;
    logic [18:0] dur;
  } result_t;

  // Results made by one character, in order; n is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: rtl/core/mmsi_parser.sv
// Command parser: token state plus one-pass decode of a character into up to two results.
module mmsi_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      char_code,
  input  logic            string_end,
  input  logic [15:0]     quarter_ticks,
  output mmsi_pkg::push_t push
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_NOTE_ACC = 3'd1,
    PH_NOTE_NUM = 3'd2,
    PH_NUM      = 3'd3,
    PH_M        = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_O    = 3'd1,
    CMD_L    = 3'd2,
    CMD_N    = 3'd3,
    CMD_P    = 3'd4,
    CMD_T    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_SHARP = 2'd1,
    ACC_FLAT  = 2'd2
  } acc_t;

  typedef struct packed {
    phase_t      ph;
    cmd_t        cmd;
    logic [3:0]  semi;
    acc_t        acc;
    logic [7:0]  num;
    logic        hd;
    logic [2:0]  oct;
    logic [17:0] dl;
    logic        skip;
  } pst_t;

  typedef struct packed {
    pst_t                s;
    logic                ev;
    mmsi_pkg::result_t   r;
  } step_t;

  localparam int OCT_SEMIS = 12;
  // codes up to 255 need at most six halvings to drop to 4 or less
  localparam int LEN_STEPS = 6;

  localparam logic [7:0] CH_0    = "0";
  localparam logic [7:0] CH_9    = "9";
  localparam logic [7:0] CH_UA   = "A";
  localparam logic [7:0] CH_UZ   = "Z";
  localparam logic [7:0] CH_A    = "a";
  localparam logic [7:0] CH_B    = "b";
  localparam logic [7:0] CH_C    = "c";
  localparam logic [7:0] CH_D    = "d";
  localparam logic [7:0] CH_E    = "e";
  localparam logic [7:0] CH_F    = "f";
  localparam logic [7:0] CH_G    = "g";
  localparam logic [7:0] CH_L    = "l";
  localparam logic [7:0] CH_M    = "m";
  localparam logic [7:0] CH_N    = "n";
  localparam logic [7:0] CH_O    = "o";
  localparam logic [7:0] CH_P    = "p";
  localparam logic [7:0] CH_S    = "s";
  localparam logic [7:0] CH_T    = "t";
  localparam logic [7:0] CH_PLUS = "+";
  localparam logic [7:0] CH_HASH = "#";
  localparam logic [7:0] CH_MIN  = "-";
  localparam logic [7:0] CH_DOT  = ".";
  localparam logic [7:0] CH_SP   = " ";
  localparam logic [7:0] CH_GT   = ">";
  localparam logic [7:0] CH_LT   = "<";

  pst_t pstate;
  pst_t pstate_next;

  function automatic mmsi_pkg::result_t mk_res(input mmsi_pkg::ev_kind_t kind,
                                               input logic [6:0] note,
                                               input logic [18:0] dur);
    mmsi_pkg::result_t r;
    r.kind = kind;
    r.note = note;
    r.dur  = dur;
    return r;
  endfunction

  // Halve time and code together until code <= 4, then scale for codes 1 and 2.
  function automatic logic [17:0] len_from_code(input logic [15:0] qt,
                                                input logic [7:0] code);
    logic [7:0]  c;
    logic [2:0]  k;
    logic [17:0] t;
    c = code;
    k = '0;
    for (int i = 0; i < LEN_STEPS; i++) begin
      if (c > 8'd4) begin
        c = c >> 1;
        k = k + 3'd1;
      end
    end
    t = 18'(qt >> k);
    if (c == 8'd1) begin
      t = t << 2;
    end else if (c == 8'd2) begin
      t = t << 1;
    end
    return t;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
  endfunction

  function automatic logic [3:0] letter_semi(input logic [7:0] lc);
    logic [3:0] v;
    case (lc)
      CH_A:    v = 4'd9;
      CH_B:    v = 4'd11;
      CH_C:    v = 4'd0;
      CH_D:    v = 4'd2;
      CH_E:    v = 4'd4;
      CH_F:    v = 4'd5;
      CH_G:    v = 4'd7;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic pst_t add_digit(input pst_t s, input logic [7:0] c);
    logic [11:0] v;
    v = 12'(s.num) * 12'd10 + 12'(c - CH_0);
    s.num = (v > 12'd255) ? 8'hFF : v[7:0];
    s.hd  = 1'b1;
    return s;
  endfunction

  function automatic pst_t start_token(input pst_t s, input phase_t ph, input cmd_t cmd);
    s.ph  = ph;
    s.cmd = cmd;
    s.acc = ACC_NONE;
    s.num = '0;
    s.hd  = 1'b0;
    return s;
  endfunction

  function automatic step_t no_event(input pst_t s);
    step_t o;
    o.s  = s;
    o.ev = 1'b0;
    o.r  = mk_res(mmsi_pkg::EV_NOTE, '0, '0);
    return o;
  endfunction

  function automatic step_t raise_error(input pst_t s, input mmsi_pkg::ev_kind_t kind);
    step_t o;
    o      = no_event(s);
    o.s.ph = PH_IDLE;
    o.s.skip = 1'b1;
    o.ev   = 1'b1;
    o.r    = mk_res(kind, '0, '0);
    return o;
  endfunction

  function automatic step_t finish_note(input pst_t s, input logic dotted,
                                        input logic [15:0] qt);
    step_t             o;
    logic [18:0]       dur;
    logic signed [9:0] n;
    logic [6:0]        note;
    o   = no_event(s);
    dur = s.hd ? 19'(len_from_code(qt, s.num)) : 19'(s.dl);
    if (dotted) begin
      dur = dur + (dur >> 1);
    end
    n = 10'(mmsi_pkg::NOTE_BASE) + 10'(s.oct) * 10'(OCT_SEMIS) + 10'(s.semi);
    if (s.acc == ACC_SHARP) begin
      n = n + 10'sd1;
    end else if (s.acc == ACC_FLAT) begin
      n = n - 10'sd1;
    end
    if (n < 10'sd0) begin
      note = '0;
    end else if (n > 10'sd127) begin
      note = 7'd127;
    end else begin
      note = n[6:0];
    end
    o.s.ph = PH_IDLE;
    o.ev   = 1'b1;
    o.r    = mk_res(mmsi_pkg::EV_NOTE, note, dur);
    return o;
  endfunction

  function automatic step_t finish_cmd(input pst_t s, input logic [15:0] qt);
    step_t o;
    o      = no_event(s);
    o.s.ph = PH_IDLE;
    case (s.cmd)
      CMD_O: begin
        if (s.num > 8'(mmsi_pkg::MAX_OCTAVE)) begin
          o = raise_error(o.s, mmsi_pkg::EV_BAD_OCTAVE);
        end else begin
          o.s.oct = s.num[2:0];
        end
      end
      CMD_L: begin
        o.s.dl = len_from_code(qt, s.num);
      end
      CMD_N: begin
        if (s.num > 8'(mmsi_pkg::MAX_NOTE_NUMBER)) begin
          o = raise_error(o.s, mmsi_pkg::EV_BAD_NOTE);
        end else if (s.num == 8'd0) begin
          o.ev = 1'b1;
          o.r  = mk_res(mmsi_pkg::EV_REST, '0, 19'(qt));
        end else begin
          o.ev = 1'b1;
          o.r  = mk_res(mmsi_pkg::EV_NOTE,
                        7'(s.num - 8'd1 + 8'(mmsi_pkg::NOTE_BASE)), 19'(s.dl));
        end
      end
      CMD_P: begin
        o.ev = 1'b1;
        o.r  = mk_res(mmsi_pkg::EV_REST, '0, 19'(len_from_code(qt, s.num)));
      end
      default: begin
      end
    endcase
    o.s.cmd = CMD_NONE;
    return o;
  endfunction

  function automatic step_t idle_char(input pst_t s, input logic [7:0] c);
    step_t      o;
    logic [7:0] lc;
    o  = no_event(s);
    lc = to_lower(c);
    if (lc inside {[CH_A:CH_G]}) begin
      o.s      = start_token(o.s, PH_NOTE_ACC, CMD_NONE);
      o.s.semi = letter_semi(lc);
    end else begin
      case (lc)
        CH_O: o.s = start_token(o.s, PH_NUM, CMD_O);
        CH_L: o.s = start_token(o.s, PH_NUM, CMD_L);
        CH_N: o.s = start_token(o.s, PH_NUM, CMD_N);
        CH_P: o.s = start_token(o.s, PH_NUM, CMD_P);
        CH_T: o.s = start_token(o.s, PH_NUM, CMD_T);
        CH_M: o.s = start_token(o.s, PH_M, CMD_NONE);
        CH_GT: begin
          if (o.s.oct < 3'(mmsi_pkg::MAX_OCTAVE)) begin
            o.s.oct = o.s.oct + 3'd1;
          end
        end
        CH_LT: begin
          if (o.s.oct != 3'd0) begin
            o.s.oct = o.s.oct - 3'd1;
          end
        end
        CH_SP: begin
        end
        default: o = raise_error(o.s, mmsi_pkg::EV_SYNTAX);
      endcase
    end
    return o;
  endfunction

  // Three possible event sources, in order: token end, new character, end-of-string flush.
  step_t             ea;
  step_t             eb;
  step_t             ec;
  logic [1:0]        ev_cnt;
  mmsi_pkg::result_t r0;
  mmsi_pkg::result_t r1;

  always_comb begin
    pst_t       s;
    logic       digit;
    logic       do_idle;
    logic [7:0] lc;
    s       = pstate;
    ea      = no_event(s);
    eb      = no_event(s);
    ec      = no_event(s);
    do_idle = 1'b0;
    digit   = char_code inside {[CH_0:CH_9]};
    lc      = to_lower(char_code);
    if (!s.skip) begin
      case (s.ph)
        PH_NOTE_ACC, PH_NOTE_NUM: begin
          if (s.ph == PH_NOTE_ACC && (char_code == CH_PLUS || char_code == CH_HASH)) begin
            s.acc = ACC_SHARP;
            s.ph  = PH_NOTE_NUM;
          end else if (s.ph == PH_NOTE_ACC && char_code == CH_MIN) begin
            s.acc = ACC_FLAT;
            s.ph  = PH_NOTE_NUM;
          end else if (digit) begin
            s    = add_digit(s, char_code);
            s.ph = PH_NOTE_NUM;
          end else begin
            ea      = finish_note(s, char_code == CH_DOT, quarter_ticks);
            s       = ea.s;
            do_idle = (char_code != CH_DOT);
          end
        end
        PH_NUM: begin
          if (digit) begin
            s = add_digit(s, char_code);
          end else if (!(char_code == CH_SP && !s.hd)) begin
            ea      = finish_cmd(s, quarter_ticks);
            s       = ea.s;
            do_idle = !s.skip;
          end
        end
        PH_M: begin
          s.ph = PH_IDLE;
          if (!(lc inside {CH_N, CH_L, CH_S, CH_F, CH_B})) begin
            ea = raise_error(s, mmsi_pkg::EV_SYNTAX);
            s  = ea.s;
          end
        end
        default: begin
          s.ph    = PH_IDLE;
          do_idle = 1'b1;
        end
      endcase
      if (do_idle) begin
        eb = idle_char(s, char_code);
        s  = eb.s;
      end
      if (string_end && !s.skip) begin
        case (s.ph)
          PH_NOTE_ACC, PH_NOTE_NUM: ec = finish_note(s, 1'b0, quarter_ticks);
          PH_NUM:                   ec = finish_cmd(s, quarter_ticks);
          PH_M:                     ec = raise_error(s, mmsi_pkg::EV_SYNTAX);
          default:                  ec = no_event(s);
        endcase
        s = ec.s;
      end
    end
    if (string_end) begin
      s.ph   = PH_IDLE;
      s.cmd  = CMD_NONE;
      s.skip = 1'b0;
    end
    pstate_next = s;
  end

  // Pack the sources that fired into the first two slots; at most two ever fire.
  always_comb begin
    ev_cnt = {1'b0, ea.ev} + {1'b0, eb.ev} + {1'b0, ec.ev};
    if (ea.ev) begin
      r0 = ea.r;
      r1 = eb.ev ? eb.r : ec.r;
    end else if (eb.ev) begin
      r0 = eb.r;
      r1 = ec.r;
    end else begin
      r0 = ec.r;
      r1 = ec.r;
    end
    push.n  = step ? ev_cnt : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate.ph   <= PH_IDLE;
      pstate.cmd  <= CMD_NONE;
      pstate.semi <= '0;
      pstate.acc  <= ACC_NONE;
      pstate.num  <= '0;
      pstate.hd   <= 1'b0;
      pstate.oct  <= 3'd3;
      pstate.dl   <= 18'(mmsi_pkg::QUARTER_RESET);
      pstate.skip <= 1'b0;
    end else if (step) begin
      pstate <= pstate_next;
    end
  end

endmodule

FILE: rtl/core/mmsi_outq.sv
// Result queue: takes up to two result words per cycle, hands out one per cycle while out_stall is low.
module mmsi_outq (
  input  logic              clk,
  input  logic              rst,
  input  mmsi_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output mmsi_pkg::result_t head_res,
  output logic              head_last
);

  localparam int PW = $clog2(mmsi_pkg::OQ_DEPTH);
  localparam int CW = $clog2(mmsi_pkg::OQ_DEPTH + 1);

  typedef struct packed {
    mmsi_pkg::result_t r;
    logic              last;
  } qent_t;

  qent_t          q [mmsi_pkg::OQ_DEPTH];
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic [CW-1:0]  count;
  logic           pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  // space for a full two-word push, pops this cycle not counted
  assign room      = (count <= CW'(mmsi_pkg::OQ_DEPTH - 2));
  assign head_res  = q[head].r;
  assign head_last = q[head].last;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q[tail] <= '{r: push.r0, last: (push.n == 2'd1)};
    end
    if (push.n == 2'd2) begin
      q[PW'(tail + PW'(1))] <= '{r: push.r1, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= PW'(tail + PW'(push.n));
      head  <= PW'(head + PW'(pop));
      count <= CW'(count + CW'(push.n) - CW'(pop));
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(mmsi_pkg::OQ_DEPTH))
    else $error("result queue over capacity");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> room)
    else $error("results pushed without room");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (count >= $past(count)))
    else $error("queue lost a word while stalled");
`endif

endmodule

FILE: rtl/core/music_macro_string_interpreter.sv
// Top level: music macro string interpreter, character in, note/rest/error words out.
//
// Input channel: one character per word (char_code, string_end), valid/stall.
// Output channel: one event per word (event_kind, note_number, duration_ticks,
// run_last), valid/stall; run_last marks the last event caused by a character.
// A character causes zero, one or two events.
// Config: cfg_write loads cfg_data into the quarter-note time; write it only
// while no character is in flight. It applies to characters taken afterwards.
// A character is taken into the input register, decoded once the result queue
// has room, and its events are written into the queue and offered from there.
// Throughput: one character per cycle while the result queue has room; the decode
// between the input register and the four-word result queue is combinational;
// two-event characters drain at one event per cycle, so a run of them fills the queue.
// Stall on the output only backs up the queue; in_stall rises once the queue
// cannot take another two events while a character waits in the input register.
// Reset (rst, synchronous) empties both stages, sets octave 3 and the default
// length and quarter time to 5000 ticks.
module music_macro_string_interpreter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        string_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [6:0]  note_number,
  output logic [18:0] duration_ticks,
  output logic        run_last
);

  logic [15:0]       quarter_ticks;
  logic              s0_valid;
  logic [7:0]        s0_char;
  logic              s0_end;
  logic              room;
  logic              step;
  logic              accept;
  mmsi_pkg::push_t   push;
  mmsi_pkg::result_t head_res;
  logic              head_last;

  assign step     = s0_valid && room;
  assign in_stall = s0_valid && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_ticks <= mmsi_pkg::QUARTER_RESET;
    end else if (cfg_write) begin
      quarter_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (accept) begin
      s0_valid <= 1'b1;
    end else if (step) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_char <= char_code;
      s0_end  <= string_end;
    end
  end

  mmsi_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .char_code     (s0_char),
    .string_end    (s0_end),
    .quarter_ticks (quarter_ticks),
    .push          (push)
  );

  mmsi_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head_res  (head_res),
    .head_last (head_last)
  );

  assign event_kind     = head_res.kind;
  assign note_number    = head_res.note;
  assign duration_ticks = head_res.dur;
  assign run_last       = head_last;

endmodule
